// ===== rtl/core/pgv_pkg.sv =====
`timescale 1ns / 1ps
package pgv_pkg;

  // Geometry of the device. Pages per block must be a power of two, so that the
  // block index and the page offset are plain fields of the page address.
  localparam int NUM_BLOCKS      = 64;
  localparam int PAGES_PER_BLOCK = 256;
  localparam int TOTAL_PAGES     = NUM_BLOCKS * PAGES_PER_BLOCK;

  localparam int BLK_W  = $clog2(NUM_BLOCKS);
  localparam int OFF_W  = $clog2(PAGES_PER_BLOCK);
  localparam int CNT_W  = $clog2(PAGES_PER_BLOCK + 1);

  // Fixed widths of the request and response fields.
  localparam int ADDR_W = 14;
  localparam int VBLK_W = 6;
  localparam int VPG_W  = 9;

  localparam logic OP_INVALIDATE = 1'b0;
  localparam logic OP_RECLAIM    = 1'b1;

  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One row of the bookkeeping memory: the block's invalid-page counter and
  // its page validity bitmap.
  typedef struct packed {
    cnt_t                       cnt;
    logic [PAGES_PER_BLOCK-1:0] valid;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INV_WR,
    ST_SCAN,
    ST_REPORT
  } state_e;

endpackage

// ===== rtl/core/pgv_if.sv =====
`timescale 1ns / 1ps
interface pgv_req_if;
  import pgv_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] page_address;

  modport source (output valid, output op, output page_address, input ready);
  modport sink   (input valid, input op, input page_address, output ready);
endinterface

interface pgv_rsp_if;
  import pgv_pkg::*;

  logic              valid;
  logic              ready;
  logic              victim_found;
  logic [VBLK_W-1:0] victim_block;
  logic              victim_all_invalid;
  logic [VPG_W-1:0]  victim_valid_pages;
  logic              count_overflow;

  modport source (output valid, output victim_found, output victim_block,
                  output victim_all_invalid, output victim_valid_pages,
                  output count_overflow, input ready);
  modport sink   (input valid, input victim_found, input victim_block,
                  input victim_all_invalid, input victim_valid_pages,
                  input count_overflow, output ready);
endinterface

// ===== rtl/core/pgv_ram.sv =====
`timescale 1ns / 1ps
module pgv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/page_invalidation_greedy_victim.sv =====
`timescale 1ns / 1ps
// Greedy garbage-collection victim selection for a flash device.
//
// Requests arrive on req_i (valid/ready). An in-range invalidate clears one
// page's validity bit and bumps the invalid-page counter of its erase block;
// a reclaim request picks the block with the most invalid pages (lowest index
// on ties), reports it and returns that block to all valid with a zero count.
// Every request yields exactly one response on rsp_o (valid/ready).
//
// An invalidate reads its row, then writes it back and registers its
// response in ST_INV_WR; the block is idle again as the response shows and
// takes the next request once the response is taken. The read-modify-write of
// one memory row sets that pace. A reclaim walks all NUM_BLOCKS counters
// through the single memory read port and one shared comparator, one block
// per cycle, then registers its response in ST_REPORT.
//
// Reset clears a per-row valid flag; a row whose flag is clear reads as all
// pages valid with a zero counter, so no clearing pass is needed and the block
// is ready as soon as reset is released. While a response waits for the
// receiver, the block holds it in its output register and accepts no new
// request until the response is taken (or is taken in the same cycle).
module page_invalidation_greedy_victim (
  input  logic      clk_i,
  input  logic      rst_ni,
  pgv_req_if.sink   req_i,
  pgv_rsp_if.source rsp_o
);
  import pgv_pkg::*;

  state_e state_q, state_d;

  logic                  req_fire;
  logic                  in_range;
  blk_t                  in_blk;
  blk_t                  raddr;
  logic                  scan_last;

  // Registers of the request being worked on.
  blk_t                  inv_blk_q;
  logic [OFF_W-1:0]      inv_off_q;
  logic                  inv_ok_q;
  blk_t                  idx_q;
  cnt_t                  most_q;
  blk_t                  best_q;

  // Per-row valid flags and the flag of the row just read.
  logic [NUM_BLOCKS-1:0] row_valid_q;
  logic                  rv_q;

  row_t                  rdata;
  row_t                  wrow;
  cnt_t                  eff_cnt;
  logic [PAGES_PER_BLOCK-1:0] eff_bits;
  logic                  sat;
  logic                  ram_we;
  logic                  load_out;
  logic                  found;
  logic                  clr_row;

  logic                  out_valid_q;
  logic                  found_d, all_inv_d, ovf_d;
  logic [VBLK_W-1:0]     vblk_d;
  logic [VPG_W-1:0]      vpg_d;

  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;

  assign in_range  = 32'(req_i.page_address) < TOTAL_PAGES;
  assign in_blk    = BLK_W'(req_i.page_address >> OFF_W);
  assign scan_last = (idx_q == BLK_W'(NUM_BLOCKS - 1));

  // Read address: the next counter during a scan, the owning block of an accepted
  // in-range invalidate, else row 0. Kept inside the row range at all times.
  always_comb begin
    if (state_q == ST_SCAN) begin
      raddr = scan_last ? '0 : idx_q + BLK_W'(1);
    end else if (req_fire && (req_i.op == OP_INVALIDATE) && in_range) begin
      raddr = in_blk;
    end else begin
      raddr = '0;
    end
  end

  pgv_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BLOCKS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (inv_blk_q),
    .wdata_i (wrow),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // A row never written since reset or since its last reclaim reads as the
  // reset value.
  assign eff_cnt  = rv_q ? rdata.cnt : '0;
  assign eff_bits = rv_q ? rdata.valid : '1;
  assign sat      = eff_cnt >= CNT_W'(PAGES_PER_BLOCK);
  assign found    = most_q != '0;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = (req_i.op == OP_RECLAIM) ? ST_SCAN : ST_INV_WR;
        end
      end
      ST_INV_WR: state_d = ST_IDLE;
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath controls and the response being built.
  always_comb begin
    ram_we     = 1'b0;
    load_out   = 1'b0;
    clr_row    = 1'b0;
    wrow.cnt   = sat ? eff_cnt : eff_cnt + CNT_W'(1);
    wrow.valid = eff_bits;
    wrow.valid[inv_off_q] = 1'b0;
    found_d    = 1'b0;
    vblk_d     = '0;
    all_inv_d  = 1'b0;
    vpg_d      = '0;
    ovf_d      = 1'b0;
    unique case (state_q)
      ST_INV_WR: begin
        ram_we   = inv_ok_q;
        load_out = 1'b1;
        ovf_d    = inv_ok_q && sat;
      end
      ST_REPORT: begin
        load_out = 1'b1;
        clr_row  = found;
        if (found) begin
          found_d   = 1'b1;
          vblk_d    = VBLK_W'(best_q);
          all_inv_d = most_q == CNT_W'(PAGES_PER_BLOCK);
          vpg_d     = VPG_W'(CNT_W'(PAGES_PER_BLOCK) - most_q);
        end
      end
      ST_IDLE, ST_SCAN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_valid_q <= '0;
      rv_q        <= 1'b0;
      inv_ok_q    <= 1'b0;
      idx_q       <= '0;
      most_q      <= '0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= row_valid_q[raddr];

      if (req_fire) begin
        inv_ok_q <= (req_i.op == OP_INVALIDATE) && in_range;
        idx_q    <= '0;
        most_q   <= '0;
        best_q   <= '0;
      end else if (state_q == ST_SCAN) begin
        // The shared comparator: strict greater keeps the lowest index on ties.
        idx_q <= idx_q + BLK_W'(1);
        if (eff_cnt > most_q) begin
          most_q <= eff_cnt;
          best_q <= idx_q;
        end
      end

      if (ram_we) begin
        row_valid_q[inv_blk_q] <= 1'b1;
      end
      if (clr_row) begin
        row_valid_q[best_q] <= 1'b0;
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  logic              found_q, all_inv_q, ovf_q;
  logic [VBLK_W-1:0] vblk_q;
  logic [VPG_W-1:0]  vpg_q;

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      inv_blk_q <= in_blk;
      inv_off_q <= req_i.page_address[OFF_W-1:0];
    end
    if (load_out) begin
      found_q   <= found_d;
      vblk_q    <= vblk_d;
      all_inv_q <= all_inv_d;
      vpg_q     <= vpg_d;
      ovf_q     <= ovf_d;
    end
  end

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.victim_found       = found_q;
  assign rsp_o.victim_block       = vblk_q;
  assign rsp_o.victim_all_invalid = all_inv_q;
  assign rsp_o.victim_valid_pages = vpg_q;
  assign rsp_o.count_overflow     = ovf_q;

endmodule

// ===== rtl/core/pgv_checker.sv =====
`timescale 1ns / 1ps
module pgv_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      req_op_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic                      found_i,
  input logic [pgv_pkg::VBLK_W-1:0] block_i,
  input logic                      all_invalid_i,
  input logic [pgv_pkg::VPG_W-1:0]  valid_pages_i,
  input logic                      overflow_i
);
  import pgv_pkg::*;

  logic req_fire;
  assign req_fire = req_valid_i && req_ready_i;

  // A waiting response holds still until the receiver takes it.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(found_i) &&
      $stable(block_i) && $stable(valid_pages_i) && $stable(overflow_i))
    else $error("response changed while stalled");

  // No new request while a response is stuck at the receiver.
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |-> !req_ready_i)
    else $error("request accepted while response stalled");

  // The block drops ready after it accepts a request, being busy with it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_ready_i)
    else $error("ready right after an accepted request");

  // An invalidate response shows up once the row write state is done.
  a_inv_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && (req_op_i == OP_INVALIDATE) |-> ##2 rsp_valid_i)
    else $error("invalidate response late");

  // Victim fields stay zero in any response without a victim.
  a_fields_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !found_i |-> block_i == '0 && !all_invalid_i &&
      valid_pages_i == '0)
    else $error("victim fields set without a victim");

endmodule

bind page_invalidation_greedy_victim pgv_checker u_pgv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .req_op_i      (req_i.op),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .found_i       (rsp_o.victim_found),
  .block_i       (rsp_o.victim_block),
  .all_invalid_i (rsp_o.victim_all_invalid),
  .valid_pages_i (rsp_o.victim_valid_pages),
  .overflow_i    (rsp_o.count_overflow)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// One response as the testbench sees it, field by field.
typedef struct packed {
  logic                       found;
  logic [pgv_pkg::VBLK_W-1:0] blk;
  logic                       all_invalid;
  logic [pgv_pkg::VPG_W-1:0]  valid_pages;
  logic                       overflow;
} gc_result_t;

// Tracks the garbage-collection bookkeeping on the testbench side: one validity
// bit per page and one invalid-page counter per erase block. Each accepted
// request leaves the response it must produce in a queue, and responses leaving
// the block are matched against that queue in order.
class victim_tracker;
  logic            page_valid[pgv_pkg::TOTAL_PAGES];
  pgv_pkg::cnt_t   invalid_count[pgv_pkg::NUM_BLOCKS];
  gc_result_t      pending_results[$];
  int              mismatch_count;

  function new();
    foreach (page_valid[p]) page_valid[p] = 1'b1;
    foreach (invalid_count[b]) invalid_count[b] = '0;
    mismatch_count = 0;
  endfunction

  // Applies one accepted request to the tracked state and queues its response.
  function void note_request(logic op, logic [pgv_pkg::ADDR_W-1:0] addr);
    gc_result_t res;
    int         blk;
    int         best;
    int         most;
    res = '0;
    if (op == pgv_pkg::OP_INVALIDATE) begin
      if (int'(addr) < pgv_pkg::TOTAL_PAGES) begin
        blk = int'(addr) / pgv_pkg::PAGES_PER_BLOCK;
        page_valid[addr] = 1'b0;
        if (int'(invalid_count[blk]) >= pgv_pkg::PAGES_PER_BLOCK) begin
          res.overflow = 1'b1;
        end else begin
          invalid_count[blk] = invalid_count[blk] + 1'b1;
        end
      end
    end else begin
      best = 0;
      most = 0;
      for (int b = 0; b < pgv_pkg::NUM_BLOCKS; b++) begin
        if (int'(invalid_count[b]) > most) begin
          most = int'(invalid_count[b]);
          best = b;
        end
      end
      if (most != 0) begin
        res.found       = 1'b1;
        res.blk         = best[pgv_pkg::VBLK_W-1:0];
        res.all_invalid = (most == pgv_pkg::PAGES_PER_BLOCK);
        res.valid_pages = pgv_pkg::VPG_W'(pgv_pkg::PAGES_PER_BLOCK - most);
        for (int p = 0; p < pgv_pkg::PAGES_PER_BLOCK; p++) begin
          page_valid[best * pgv_pkg::PAGES_PER_BLOCK + p] = 1'b1;
        end
        invalid_count[best] = '0;
      end
    end
    pending_results.push_back(res);
  endfunction

  function void check_result(gc_result_t got);
    gc_result_t exp;
    if (pending_results.size() == 0) begin
      $error("response with no request outstanding");
      mismatch_count++;
      return;
    end
    exp = pending_results.pop_front();
    if (got.found !== exp.found) begin
      $error("victim_found: expected %0d, got %0d", exp.found, got.found);
      mismatch_count++;
    end
    if (got.blk !== exp.blk) begin
      $error("victim_block: expected %0d, got %0d", exp.blk, got.blk);
      mismatch_count++;
    end
    if (got.all_invalid !== exp.all_invalid) begin
      $error("victim_all_invalid: expected %0d, got %0d", exp.all_invalid,
             got.all_invalid);
      mismatch_count++;
    end
    if (got.valid_pages !== exp.valid_pages) begin
      $error("victim_valid_pages: expected %0d, got %0d", exp.valid_pages,
             got.valid_pages);
      mismatch_count++;
    end
    if (got.overflow !== exp.overflow) begin
      $error("count_overflow: expected %0d, got %0d", exp.overflow, got.overflow);
      mismatch_count++;
    end
  endfunction
endclass

module tb;
  import pgv_pkg::*;

  // A reclaim walks every block counter, so it is the slowest request. The run
  // limit below allows every request that long, plus the worst sender gap and a
  // generous receiver stall.
  localparam int RECLAIM_LATENCY = NUM_BLOCKS + 2;
  localparam int LONG_HOLD       = 300;
  localparam int CYCLE_LIMIT     = 400000;

  typedef enum int {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic clk_i;
  logic rst_ni;

  pgv_req_if req_if ();
  pgv_rsp_if rsp_if ();

  page_invalidation_greedy_victim i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  victim_tracker gc_state = new();

  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_wanted = 1'b0;

  // Remaining requests in the sender's current burst.
  int burst_left = 0;

  int cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The run is cut off and fails once the cycle counter passes CYCLE_LIMIT, so a stuck block cannot hang it.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Every handshake on the response side is checked at the rising edge, using
  // the values that stood just before it.
  always @(posedge clk_i) begin
    gc_result_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.found       = rsp_if.victim_found;
      got.blk         = rsp_if.victim_block;
      got.all_invalid = rsp_if.victim_all_invalid;
      got.valid_pages = rsp_if.victim_valid_pages;
      got.overflow    = rsp_if.count_overflow;
      gc_state.check_result(got);
    end
  end

  // The receiver cycles through stall modes of random length: always ready,
  // mostly ready, rarely ready and a strict toggle. When the stimulus asks for
  // it, ready drops for a long stretch so that the block's output register
  // stays full and the request side backs up behind it.
  initial begin
    rx_mode_e rx_mode;
    int       mode_left;
    logic     toggle_bit;
    rx_mode    = RX_STEADY;
    mode_left  = 0;
    toggle_bit = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (rx_mode)
          RX_STEADY: begin
            rsp_if.ready <= 1'b1;
          end
          RX_MOSTLY: begin
            rsp_if.ready <= ($urandom_range(0, 3) != 0);
          end
          RX_SPARSE: begin
            rsp_if.ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            toggle_bit = ~toggle_bit;
            rsp_if.ready <= toggle_bit;
          end
        endcase
      end
    end
  end

  // Offers one request and returns once the block has accepted it. The sender
  // works in bursts: at the start of each burst it may pause for a random gap,
  // and within a burst valid stays high from one request to the next.
  task automatic send_request(input logic op, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid        <= 1'b1;
    req_if.op           <= op;
    req_if.page_address <= addr;
    forever begin
      @(posedge clk_i);
      if (req_if.ready) break;
    end
    gc_state.note_request(op, addr);
  endtask

  // Builds a page address from an erase block and a page offset within it.
  function automatic logic [ADDR_W-1:0] page_of(int blk, int off);
    return ADDR_W'(blk * PAGES_PER_BLOCK + off);
  endfunction

  initial begin
    int hot_blocks[4];
    int sat_block;
    int blk;
    int n;

    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.op           = OP_INVALIDATE;
    req_if.page_address = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. A reclaim straight after reset finds no victim.
    send_request(OP_RECLAIM, '0);
    // First and last page of the device: a one-all tie between block 0 and
    // block 63 goes to the lower index, and the next reclaim takes block 63.
    send_request(OP_INVALIDATE, '0);
    send_request(OP_INVALIDATE, '1);
    send_request(OP_RECLAIM, '0);
    send_request(OP_RECLAIM, '1);
    send_request(OP_RECLAIM, '0);
    // A tie where the lower-index block was touched second still goes to it.
    send_request(OP_INVALIDATE, page_of(5, 0));
    send_request(OP_INVALIDATE, page_of(2, PAGES_PER_BLOCK - 1));
    send_request(OP_RECLAIM, '0);
    send_request(OP_RECLAIM, '0);
    // Invalidating a page that is already invalid still bumps the counter, so
    // block 42 outranks block 21 here. The addresses alternate every bit.
    send_request(OP_INVALIDATE, 14'h2AAA);
    send_request(OP_INVALIDATE, 14'h2AAA);
    send_request(OP_INVALIDATE, 14'h1555);
    send_request(OP_RECLAIM, 14'h3FFF);
    send_request(OP_RECLAIM, 14'h2AAA);
    send_request(OP_RECLAIM, 14'h1555);

    // Ask for one long receiver hold-off while the sender keeps offering.
    hold_wanted = 1'b1;

    // Fill one block past its page count: the counter saturates and further
    // invalidates report overflow. The reclaim then finds a wholly invalid
    // victim with no valid pages left.
    sat_block = $urandom_range(0, NUM_BLOCKS - 1);
    n = $urandom_range(PAGES_PER_BLOCK + 2, PAGES_PER_BLOCK + 14);
    repeat (n) begin
      send_request(OP_INVALIDATE, page_of(sat_block, $urandom_range(0, PAGES_PER_BLOCK - 1)));
    end
    send_request(OP_RECLAIM, ADDR_W'($urandom));

    // Mixed traffic. Most invalidates land in a few hot blocks so that the
    // counters grow and the greedy choice has real contenders; the rest are
    // spread over the whole device. Reclaims carry a random, ignored address.
    for (int i = 0; i < 370; i++) begin
      if (i % 100 == 0) begin
        foreach (hot_blocks[h]) hot_blocks[h] = $urandom_range(0, NUM_BLOCKS - 1);
      end
      if ($urandom_range(0, 9) == 0) begin
        send_request(OP_RECLAIM, ADDR_W'($urandom));
      end else if ($urandom_range(0, 9) < 6) begin
        blk = hot_blocks[$urandom_range(0, 3)];
        send_request(OP_INVALIDATE, page_of(blk, $urandom_range(0, PAGES_PER_BLOCK - 1)));
      end else begin
        send_request(OP_INVALIDATE, ADDR_W'($urandom));
      end
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;

    // Drain every outstanding response, then give a stray one time to show.
    while (gc_state.pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * RECLAIM_LATENCY) @(posedge clk_i);

    if (gc_state.mismatch_count == 0 && gc_state.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pgv_pkg.sv
rtl/core/pgv_if.sv
rtl/core/pgv_ram.sv
rtl/core/page_invalidation_greedy_victim.sv
rtl/core/pgv_checker.sv
tb/tb.sv
